### rtl/core/rgb_color_sequence_fader_core_defines.svh
// assertion macros for the rgb color sequence fader core
// needs a clock named aclk and an active-low reset named aresetn in the using scope
`ifndef RGB_COLOR_SEQUENCE_FADER_CORE_DEFINES_SVH
`define RGB_COLOR_SEQUENCE_FADER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RGBF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fader assertion failed");
`define RGBF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fader assertion failed");
`else
`define RGBF_ASSERT_IMPL(label, ante, cons)
`define RGBF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/rgbf_pkg.sv
// shared types, constants and codes of the rgb color sequence fader
// no dependencies
package rgbf_pkg;

    localparam int MAX_COLORS = 16;
    localparam int IDX_W      = $clog2(MAX_COLORS);
    localparam int CNT_W      = $clog2(MAX_COLORS + 1);
    localparam int LVL_W      = 8;
    localparam int DUR_W      = 16;
    localparam int CHANNELS   = 3;
    localparam int COLOR_W    = CHANNELS * LVL_W;
    localparam int ENTRY_W    = COLOR_W + DUR_W;
    localparam int PROD_W     = LVL_W + DUR_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CC_W       = 5;

    localparam logic [LVL_W-1:0] LVL_MAX = 8'hFF;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic REG_COLOR_COUNT = 1'b0;
    localparam logic REG_ONE_SHOT    = 1'b1;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [3:0]       entry_index;
        logic [LVL_W-1:0] red_value;
        logic [LVL_W-1:0] green_value;
        logic [LVL_W-1:0] blue_value;
        logic [DUR_W-1:0] duration_ticks;
    } in_item_t;

    typedef struct packed {
        logic [LVL_W-1:0] red_duty;
        logic [LVL_W-1:0] green_duty;
        logic [LVL_W-1:0] blue_duty;
        logic [3:0]       segment_now;
        logic             still_running;
    } out_item_t;

    typedef struct packed {
        logic [CC_W-1:0] color_count;
        logic            one_shot;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_LOAD_A   = 6'b000010,
        ST_LOAD_B   = 6'b000100,
        ST_DIVIDE   = 6'b001000,
        ST_START_RD = 6'b010000,
        ST_EMIT     = 6'b100000
    } state_t;

endpackage

### rtl/core/rgbf_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
module rgbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/rgbf_cfg.sv
// apb configuration registers: color count and one-shot mode
// depends on rgbf_pkg
module rgbf_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rgbf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rgbf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rgbf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output rgbf_pkg::cfg_t                 cfg
);
    import rgbf_pkg::*;

    logic [CC_W-1:0] color_count_reg;
    logic            one_shot_reg;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_count_reg <= CC_W'(1);
            one_shot_reg    <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_COLOR_COUNT: color_count_reg <= pwdata[CC_W-1:0];
                REG_ONE_SHOT:    one_shot_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_COLOR_COUNT: prdata = APB_DATA_W'(color_count_reg);
            REG_ONE_SHOT:    prdata = APB_DATA_W'(one_shot_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.color_count = color_count_reg;
    assign cfg.one_shot    = one_shot_reg;

endmodule

### rtl/core/rgbf_div.sv
// three-lane restoring divider, one quotient bit per lane per cycle
// depends on rgbf_pkg
module rgbf_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rgbf_pkg::DUR_W-1:0]  divisor,
    input  logic [rgbf_pkg::PROD_W-1:0] dividend [rgbf_pkg::CHANNELS],
    output logic [rgbf_pkg::PROD_W-1:0] quotient [rgbf_pkg::CHANNELS],
    output rgbf_pkg::div_stat_t         stat
);
    import rgbf_pkg::*;

    localparam int STEP_W = $clog2(PROD_W + 1);

    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;
    logic [DUR_W-1:0]  dvsr_reg;
    logic [PROD_W-1:0] dvd_reg  [CHANNELS];
    logic [DUR_W-1:0]  rem_reg  [CHANNELS];
    logic [PROD_W-1:0] dvd_next [CHANNELS];
    logic [DUR_W-1:0]  rem_next [CHANNELS];

    always_comb begin
        logic [DUR_W:0] shifted;
        logic           ge;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            shifted      = {rem_reg[ch], dvd_reg[ch][PROD_W-1]};
            ge           = shifted >= {1'b0, dvsr_reg};
            rem_next[ch] = ge ? DUR_W'(shifted - {1'b0, dvsr_reg}) : shifted[DUR_W-1:0];
            dvd_next[ch] = {dvd_reg[ch][PROD_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= STEP_W'(PROD_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - STEP_W'(1);
            done_reg <= cnt_reg == STEP_W'(1);
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvsr_reg <= divisor;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                dvd_reg[ch] <= dividend[ch];
                rem_reg[ch] <= '0;
            end
        end else if (cnt_reg != '0) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                dvd_reg[ch] <= dvd_next[ch];
                rem_reg[ch] <= rem_next[ch];
            end
        end
    end

    assign quotient  = dvd_reg;
    assign stat.busy = cnt_reg != '0;
    assign stat.done = done_reg;

endmodule

### rtl/core/rgb_color_sequence_fader_core.sv
// tick: two table reads (current and next entry), the 24-step divider, then the output
// register; start: one table read, then the output register; both wait while a result is held
// write: no result, new transfer the next cycle; one item at a time
// the next transfer is taken while a result waits at the output
// synchronous active-low reset clears segment, position, running flag and handshake
// state; table contents are undefined until written
`include "rgb_color_sequence_fader_core_defines.svh"
module rgb_color_sequence_fader_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rgbf_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rgbf_pkg::out_item_t             m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgbf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rgbf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rgbf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import rgbf_pkg::*;

    cfg_t      cfg;
    div_stat_t div_stat;
    state_t    state_reg, state_next;

    logic [IDX_W-1:0]   seg_reg;
    logic [DUR_W-1:0]   pos_reg;
    logic               running_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic [IDX_W-1:0]   seg_out_reg;
    logic [DUR_W-1:0]   pos_cur_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [COLOR_W-1:0] a_color_reg;
    logic               neg_reg [CHANNELS];
    logic [LVL_W-1:0]   res_lvl_reg [CHANNELS];

    logic               accept;
    logic               is_tick;
    logic               is_write;
    logic               is_start;
    logic               out_free;
    logic [CNT_W-1:0]   active_cnt;
    logic [CNT_W-1:0]   seg_plus;
    logic [IDX_W-1:0]   next_seg;
    logic [DUR_W-1:0]   dur_eff;
    logic [DUR_W-1:0]   pos_inc;
    logic               seg_end;

    logic               ram_we;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               div_start;
    logic [PROD_W-1:0]  dividend [CHANNELS];
    logic [PROD_W-1:0]  quotient [CHANNELS];
    logic               neg_now [CHANNELS];
    logic [LVL_W-1:0]   fin_lvl [CHANNELS];

    rgbf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready  = state_reg == ST_IDLE;
    assign accept   = s_valid && s_ready;
    assign is_tick  = s_data.cmd == CMD_TICK;
    assign is_write = s_data.cmd == CMD_WRITE;
    assign is_start = s_data.cmd == CMD_START;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        if (cfg.color_count == '0) begin
            active_cnt = CNT_W'(1);
        end else if (32'(cfg.color_count) > MAX_COLORS) begin
            active_cnt = CNT_W'(MAX_COLORS);
        end else begin
            active_cnt = CNT_W'(cfg.color_count);
        end
    end

    assign seg_plus = CNT_W'(seg_reg) + CNT_W'(1);
    assign next_seg = (seg_plus >= active_cnt) ? '0 : IDX_W'(seg_plus);

    assign ram_we    = accept && is_write && (32'(s_data.entry_index) < MAX_COLORS);
    assign ram_wdata = {s_data.red_value, s_data.green_value, s_data.blue_value,
                        s_data.duration_ticks};
    assign ram_re    = (accept && (is_start || (is_tick && running_reg)))
                    || (state_reg == ST_LOAD_A);

    always_comb begin
        if (state_reg == ST_LOAD_A) begin
            ram_raddr = next_seg;
        end else if (is_start) begin
            ram_raddr = '0;
        end else begin
            ram_raddr = seg_reg;
        end
    end

    rgbf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_COLORS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (IDX_W'(s_data.entry_index)),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign dur_eff = (ram_rdata[DUR_W-1:0] == '0) ? DUR_W'(1) : ram_rdata[DUR_W-1:0];
    assign pos_inc = pos_reg + DUR_W'(1);
    assign seg_end = (pos_inc == '0) || (pos_inc >= dur_eff);

    always_comb begin
        logic [LVL_W-1:0] from_lvl;
        logic [LVL_W-1:0] to_lvl;
        logic [LVL_W-1:0] mag;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            from_lvl     = a_color_reg[COLOR_W-1-ch*LVL_W -: LVL_W];
            to_lvl       = ram_rdata[ENTRY_W-1-ch*LVL_W -: LVL_W];
            neg_now[ch]  = to_lvl < from_lvl;
            mag          = neg_now[ch] ? from_lvl - to_lvl : to_lvl - from_lvl;
            dividend[ch] = PROD_W'(pos_cur_reg) * PROD_W'(mag);
        end
    end

    assign div_start = state_reg == ST_LOAD_B;

    rgbf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (dur_reg),
        .dividend (dividend),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb begin
        logic [LVL_W-1:0]  from_lvl;
        logic [PROD_W:0]   sum;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            from_lvl = a_color_reg[COLOR_W-1-ch*LVL_W -: LVL_W];
            sum      = (PROD_W+1)'(quotient[ch]) + (PROD_W+1)'(from_lvl);
            if (neg_reg[ch]) begin
                fin_lvl[ch] = (quotient[ch] > PROD_W'(from_lvl))
                            ? '0 : LVL_W'(PROD_W'(from_lvl) - quotient[ch]);
            end else begin
                fin_lvl[ch] = (sum > (PROD_W+1)'(LVL_MAX)) ? LVL_MAX : LVL_W'(sum);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_start) begin
                    state_next = ST_START_RD;
                end else if (accept && is_tick && running_reg) begin
                    state_next = ST_LOAD_A;
                end
            end
            ST_LOAD_A:   state_next = ST_LOAD_B;
            ST_LOAD_B:   state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (div_stat.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_START_RD: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seg_reg     <= '0;
            pos_reg     <= '0;
            running_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && accept && is_start) begin
                seg_reg     <= '0;
                pos_reg     <= '0;
                running_reg <= 1'b1;
            end
            if (state_reg == ST_LOAD_A) begin
                if (seg_end) begin
                    seg_reg <= next_seg;
                    pos_reg <= '0;
                    if (cfg.one_shot) begin
                        running_reg <= 1'b0;
                    end
                end else begin
                    pos_reg <= pos_inc;
                end
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            pos_cur_reg <= pos_reg;
            seg_out_reg <= seg_reg;
        end
        if (state_reg == ST_LOAD_A) begin
            a_color_reg <= ram_rdata[ENTRY_W-1:DUR_W];
            dur_reg     <= dur_eff;
        end
        if (state_reg == ST_LOAD_B) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                neg_reg[ch] <= neg_now[ch];
            end
        end
        if (state_reg == ST_DIVIDE && div_stat.done) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                res_lvl_reg[ch] <= fin_lvl[ch];
            end
        end
        if (state_reg == ST_START_RD) begin
            seg_out_reg <= '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                res_lvl_reg[ch] <= ram_rdata[ENTRY_W-1-ch*LVL_W -: LVL_W];
            end
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_data_reg.red_duty      <= res_lvl_reg[0];
            m_data_reg.green_duty    <= res_lvl_reg[1];
            m_data_reg.blue_duty     <= res_lvl_reg[2];
            m_data_reg.segment_now   <= 4'(seg_out_reg);
            m_data_reg.still_running <= running_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RGBF_ASSERT_IMPL(a_div_only_in_divide, div_stat.busy, state_reg == ST_DIVIDE)
    `RGBF_ASSERT_NEXT(a_emit_loads_output, (state_reg == ST_EMIT) && out_free, m_valid && s_ready)
    `RGBF_ASSERT_NEXT(a_start_resets_fade, accept && is_start,
        (state_reg == ST_START_RD) && running_reg && (seg_reg == '0) && (pos_reg == '0))

endmodule
